[sv/nested_region_cycle_profiler_top_defines.svh]
// assertion macros of the profiler rtl, used by its datapath
// expects aclk and aresetn in the scope of each use
`ifndef NESTED_REGION_CYCLE_PROFILER_TOP_DEFINES_SVH
`define NESTED_REGION_CYCLE_PROFILER_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define NRCP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define NRCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/nrcp_pkg.sv]
// shared types, codes and defaults of the nested region cycle profiler
// no dependencies
package nrcp_pkg;

    localparam int MODE_W   = 2;
    localparam int ANCHOR_W = 8;
    localparam int TS_W     = 64;
    localparam int CNT_W    = 64;
    localparam int STAT_W   = 2;
    localparam int ANCHOR_N = 1 << ANCHOR_W;

    localparam int REGIONS_DEF    = 256;
    localparam int NEST_DEPTH_DEF = 16;

    localparam logic [MODE_W-1:0] MODE_START = 2'd0;
    localparam logic [MODE_W-1:0] MODE_END   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [ANCHOR_W-1:0] anchor_index;
        logic [TS_W-1:0]     timestamp;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [ANCHOR_W-1:0] region_out;
        logic [CNT_W-1:0]    inclusive_cycles;
        logic [CNT_W-1:0]    exclusive_cycles;
        logic [CNT_W-1:0]    hits;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic accept;
        logic rd_report;
        logic rd_end;
        logic push;
        logic finish;
        logic upd1;
        logic upd2;
        logic emit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic op_start;
        logic op_end;
        logic stk_empty;
        logic stk_full;
        logic out_free;
    } dp_status_t;

endpackage

[sv/nrcp_ctrl.sv]
// sequencing state machine of the profiler
// depends on nrcp_pkg
module nrcp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  nrcp_pkg::dp_status_t status,
    output nrcp_pkg::dp_cmd_t    cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_FRAME = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_UPD1  = 3'd4;
    localparam logic [2:0] ST_UPD2  = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_FRAME;
                end
            end
            ST_FRAME: begin
                cmd.rd_report = 1'b1;
                state_next    = ST_READ;
            end
            ST_READ: begin
                if (status.op_end && !status.stk_empty) begin
                    cmd.rd_end = 1'b1;
                    state_next = ST_UPD1;
                end else begin
                    cmd.finish = 1'b1;
                    cmd.push   = status.op_start && !status.stk_full;
                    state_next = ST_EMIT;
                end
            end
            ST_UPD1: begin
                cmd.upd1   = 1'b1;
                state_next = ST_UPD2;
            end
            ST_UPD2: begin
                cmd.upd2   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/nrcp_datapath.sv]
// frame stack, region tables, arithmetic and output register of the profiler
// depends on nrcp_pkg and nested_region_cycle_profiler_top_defines.svh
`include "nested_region_cycle_profiler_top_defines.svh"

module nrcp_datapath #(
    parameter int REGIONS    = nrcp_pkg::REGIONS_DEF,
    parameter int NEST_DEPTH = nrcp_pkg::NEST_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  nrcp_pkg::in_item_t   s_item,
    input  nrcp_pkg::dp_cmd_t    cmd,
    output nrcp_pkg::dp_status_t status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output nrcp_pkg::out_item_t  m_item
);

    localparam int RIW = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int FIW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int SPW = $clog2(NEST_DEPTH + 1);
    localparam int TW  = nrcp_pkg::TS_W;
    localparam int CW  = nrcp_pkg::CNT_W;

    // anchor to region index, folded by the region count
    logic [RIW-1:0] region_lut [nrcp_pkg::ANCHOR_N];
    for (genvar g = 0; g < nrcp_pkg::ANCHOR_N; g++) begin : g_lut
        assign region_lut[g] = RIW'(g % REGIONS);
    end

    // event registers
    logic [nrcp_pkg::MODE_W-1:0] mode_reg;
    logic [RIW-1:0]              region_reg;
    logic [TW-1:0]               ts_reg;

    // control state
    logic [SPW-1:0] sp_reg;
    logic [RIW-1:0] cur_reg;
    logic [RIW-1:0] clr_reg;
    logic           m_valid_reg;

    // frame stack
    logic [RIW-1:0] fr_region_mem [NEST_DEPTH];
    logic [RIW-1:0] fr_parent_mem [NEST_DEPTH];
    logic [TW-1:0]  fr_start_mem  [NEST_DEPTH];
    logic [CW-1:0]  fr_oldinc_mem [NEST_DEPTH];
    logic [RIW-1:0] fr_region_q;
    logic [RIW-1:0] fr_parent_q;
    logic [TW-1:0]  fr_start_q;
    logic [CW-1:0]  fr_oldinc_q;

    // region tables
    logic [CW-1:0] inc_mem [REGIONS];
    logic [CW-1:0] exc_mem [REGIONS];
    logic [CW-1:0] hit_mem [REGIONS];
    logic [CW-1:0] inc_q;
    logic [CW-1:0] exc_a_q;
    logic [CW-1:0] exc_b_q;
    logic [CW-1:0] hit_q;

    // end-event working registers
    logic [CW-1:0] elapsed_reg;
    logic [CW-1:0] excp_new_reg;
    logic [CW-1:0] inc_new_reg;
    logic [CW-1:0] hit_new_reg;

    nrcp_pkg::out_item_t res_reg;
    nrcp_pkg::out_item_t m_item_reg;

    logic [SPW-1:0]              sp_m1;
    logic [FIW-1:0]              fr_rd_idx;
    logic [FIW-1:0]              fr_wr_idx;
    logic                        stk_empty;
    logic                        stk_full;
    logic [RIW-1:0]              rep_addr;
    logic [RIW-1:0]              addr_a;
    logic [CW-1:0]               exc_par_new;
    logic [CW-1:0]               inc_new;
    logic [CW-1:0]               hit_new;
    logic [CW-1:0]               exc_self_new;
    logic [nrcp_pkg::STAT_W-1:0] simple_status;

    assign sp_m1     = sp_reg - SPW'(1);
    assign fr_rd_idx = sp_m1[FIW-1:0];
    assign fr_wr_idx = sp_reg[FIW-1:0];
    assign stk_empty = (sp_reg == '0);
    assign stk_full  = (sp_reg == SPW'(NEST_DEPTH));

    // a failed end reports the current region, everything else the anchor
    assign rep_addr = (mode_reg == nrcp_pkg::MODE_END) ? cur_reg : region_reg;
    assign addr_a   = cmd.rd_end ? fr_region_q : rep_addr;

    assign exc_par_new  = exc_b_q - elapsed_reg;
    assign inc_new      = fr_oldinc_q + elapsed_reg;
    assign hit_new      = hit_q + CW'(1);
    // recursion into the parent sees the parent update first
    assign exc_self_new = ((fr_region_q == fr_parent_q) ? excp_new_reg : exc_a_q) + elapsed_reg;

    always_comb begin
        simple_status = nrcp_pkg::STAT_OK;
        if (mode_reg == nrcp_pkg::MODE_START && stk_full) begin
            simple_status = nrcp_pkg::STAT_FULL;
        end else if (mode_reg == nrcp_pkg::MODE_END) begin
            simple_status = nrcp_pkg::STAT_EMPTY;
        end
    end

    assign status.clear_last = (clr_reg == RIW'(REGIONS - 1));
    assign status.op_start   = (mode_reg == nrcp_pkg::MODE_START);
    assign status.op_end     = (mode_reg == nrcp_pkg::MODE_END);
    assign status.stk_empty  = stk_empty;
    assign status.stk_full   = stk_full;
    assign status.out_free   = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg      <= '0;
            cur_reg     <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear) begin
                clr_reg <= clr_reg + RIW'(1);
            end
            if (cmd.push) begin
                sp_reg  <= sp_reg + SPW'(1);
                cur_reg <= region_reg;
            end else if (cmd.upd2) begin
                sp_reg  <= sp_m1;
                cur_reg <= fr_parent_q;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // event capture, working registers and result
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mode_reg   <= s_item.mode;
            region_reg <= region_lut[s_item.anchor_index];
            ts_reg     <= s_item.timestamp;
        end
        if (cmd.rd_end) begin
            elapsed_reg <= ts_reg - fr_start_q;
        end
        if (cmd.upd1) begin
            excp_new_reg <= exc_par_new;
            inc_new_reg  <= inc_new;
            hit_new_reg  <= hit_new;
        end
        if (cmd.finish) begin
            res_reg.status           <= simple_status;
            res_reg.region_out       <= nrcp_pkg::ANCHOR_W'(rep_addr);
            res_reg.inclusive_cycles <= inc_q;
            res_reg.exclusive_cycles <= exc_a_q;
            res_reg.hits             <= hit_q;
        end else if (cmd.upd2) begin
            res_reg.status           <= nrcp_pkg::STAT_OK;
            res_reg.region_out       <= nrcp_pkg::ANCHOR_W'(fr_region_q);
            res_reg.inclusive_cycles <= inc_new_reg;
            res_reg.exclusive_cycles <= exc_self_new;
            res_reg.hits             <= hit_new_reg;
        end
        if (cmd.emit) begin
            m_item_reg <= res_reg;
        end
    end

    // frame stack memory
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            fr_region_mem[fr_wr_idx] <= region_reg;
            fr_parent_mem[fr_wr_idx] <= cur_reg;
            fr_start_mem[fr_wr_idx]  <= ts_reg;
            fr_oldinc_mem[fr_wr_idx] <= inc_q;
        end
        if (cmd.rd_report && !stk_empty) begin
            fr_region_q <= fr_region_mem[fr_rd_idx];
            fr_parent_q <= fr_parent_mem[fr_rd_idx];
            fr_start_q  <= fr_start_mem[fr_rd_idx];
            fr_oldinc_q <= fr_oldinc_mem[fr_rd_idx];
        end
    end

    // inclusive table
    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            inc_mem[clr_reg] <= '0;
        end else if (cmd.upd1) begin
            inc_mem[fr_region_q] <= inc_new;
        end
        if (cmd.rd_report) begin
            inc_q <= inc_mem[rep_addr];
        end
    end

    // exclusive table: parent written first, region second
    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            exc_mem[clr_reg] <= '0;
        end else if (cmd.upd1) begin
            exc_mem[fr_parent_q] <= exc_par_new;
        end else if (cmd.upd2) begin
            exc_mem[fr_region_q] <= exc_self_new;
        end
        if (cmd.rd_report || cmd.rd_end) begin
            exc_a_q <= exc_mem[addr_a];
        end
        if (cmd.rd_end) begin
            exc_b_q <= exc_mem[fr_parent_q];
        end
    end

    // hit table
    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            hit_mem[clr_reg] <= '0;
        end else if (cmd.upd1) begin
            hit_mem[fr_region_q] <= hit_new;
        end
        if (cmd.rd_report || cmd.rd_end) begin
            hit_q <= hit_mem[addr_a];
        end
    end

    `NRCP_ASSERT_NOW(a_push_room, cmd.push, !stk_full, "frame pushed onto a full stack")
    `NRCP_ASSERT_NOW(a_pop_frame, cmd.rd_end, !stk_empty, "frame popped from an empty stack")
    `NRCP_ASSERT_NEXT(a_upd_pair, cmd.upd1, cmd.upd2, "table update split from its second half")
    `NRCP_ASSERT_NOW(a_emit_free, cmd.emit, !m_valid_reg || m_ready, "result overwrote a pending item")

endmodule

[sv/nested_region_cycle_profiler_top.sv]
// start, read and rejected events reach m_ through accept, the frame and table read and emit;
// a closed region adds the end read and the table update; a new event is taken only once
// the last result is in the output register; the sequence is set by registered reads of the
// frame stack and tables and the two-step read-modify-write of the exclusive table on a pop
// reset (aresetn, synchronous, active low) empties the stack, makes the root current and starts
// a clearing pass over all REGIONS entries of the tables; s_ready stays low until it is done
module nested_region_cycle_profiler_top #(
    parameter int REGIONS    = nrcp_pkg::REGIONS_DEF,
    parameter int NEST_DEPTH = nrcp_pkg::NEST_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // event items
    input  logic                s_valid,
    output logic                s_ready,
    input  nrcp_pkg::in_item_t  s_item,
    // result items, one per event
    output logic                m_valid,
    input  logic                m_ready,
    output nrcp_pkg::out_item_t m_item
);

    // command and status between the sequencer and the datapath
    nrcp_pkg::dp_cmd_t    cmd;
    nrcp_pkg::dp_status_t status;

    // sequencer: clear pass, accept, table reads, optional two-step update, emit
    nrcp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath: frame stack, inclusive / exclusive / hit tables, output register
    // the output register lets the next item enter while a result waits on m_ready
    nrcp_datapath #(
        .REGIONS    (REGIONS),
        .NEST_DEPTH (NEST_DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

[sim/nested_region_cycle_profiler_top_tb.sv]
// self-checking testbench for nested_region_cycle_profiler_top
// depends on nrcp_pkg and the profiler rtl; a directed table, then random event streams
`timescale 1ns / 1ps

module nested_region_cycle_profiler_top_tb;

    localparam int PROF_REGIONS = nrcp_pkg::REGIONS_DEF;
    localparam int PROF_DEPTH   = nrcp_pkg::NEST_DEPTH_DEF;
    localparam int FRAME_IW     = (PROF_DEPTH > 1) ? $clog2(PROF_DEPTH) : 1;
    localparam int SCRIPT_ROWS  = 19;
    localparam int SCRIPT_IW    = $clog2(SCRIPT_ROWS);
    localparam int RANDOM_ITEMS = 1000;
    localparam int CYCLE_LIMIT  = 250000;
    localparam int SETTLE_CYCLES = 12;
    localparam int REPORT_MAX   = 10;
    // the spare mode code behaves as a read
    localparam logic [nrcp_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

    // one row of the directed table; reps repeats the row with a rising timestamp
    typedef struct packed {
        nrcp_pkg::in_item_t  ev;
        logic [7:0]          reps;
        logic                typed;
        nrcp_pkg::out_item_t want;
    } script_row_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    nrcp_pkg::in_item_t  s_item  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    nrcp_pkg::out_item_t m_item;

    // predicted profiler state
    bit [nrcp_pkg::ANCHOR_W-1:0] active_region;
    int                          nest_fill;
    bit [nrcp_pkg::ANCHOR_W-1:0] frame_rgn    [PROF_DEPTH];
    bit [nrcp_pkg::ANCHOR_W-1:0] frame_parent [PROF_DEPTH];
    bit [nrcp_pkg::TS_W-1:0]     frame_start  [PROF_DEPTH];
    bit [nrcp_pkg::CNT_W-1:0]    frame_incl   [PROF_DEPTH];
    bit [nrcp_pkg::CNT_W-1:0]    incl_total   [PROF_REGIONS];
    bit [nrcp_pkg::CNT_W-1:0]    excl_total   [PROF_REGIONS];
    bit [nrcp_pkg::CNT_W-1:0]    hit_total    [PROF_REGIONS];

    nrcp_pkg::out_item_t pending_reports[$];
    script_row_t         script[SCRIPT_ROWS];
    int                  valid_hold_pct = 28;
    int                  ready_hold_pct = 70;
    int                  mismatch_count = 0;
    int                  cycle_count    = 0;
    bit [nrcp_pkg::TS_W-1:0]     stamp_clock = '0;
    bit [nrcp_pkg::ANCHOR_W-1:0] region_pool[6] = '{8'h00, 8'h01, 8'h02, 8'h07, 8'h80, 8'hFF};

    nested_region_cycle_profiler_top #(
        .REGIONS    (PROF_REGIONS),
        .NEST_DEPTH (PROF_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #4 aclk = ~aclk;

    // totals of a region that has never been closed
    function automatic nrcp_pkg::out_item_t zero_report(logic [nrcp_pkg::STAT_W-1:0] stat,
                                                        logic [nrcp_pkg::ANCHOR_W-1:0] rgn);
        nrcp_pkg::out_item_t rep;
        rep            = '0;
        rep.status     = stat;
        rep.region_out = rgn;
        return rep;
    endfunction

    // applies one event to the predicted tables and returns the report it causes
    function automatic nrcp_pkg::out_item_t account_event(nrcp_pkg::in_item_t ev);
        bit [nrcp_pkg::ANCHOR_W-1:0] rgn;
        bit [nrcp_pkg::ANCHOR_W-1:0] parent;
        bit [nrcp_pkg::TS_W-1:0]     elapsed;
        bit [nrcp_pkg::STAT_W-1:0]   stat;
        bit [FRAME_IW-1:0]           slot;
        nrcp_pkg::out_item_t         rep;
        rgn  = nrcp_pkg::ANCHOR_W'(ev.anchor_index % PROF_REGIONS);
        stat = nrcp_pkg::STAT_OK;
        case (ev.mode)
            nrcp_pkg::MODE_START: begin
                if (nest_fill >= PROF_DEPTH) begin
                    stat = nrcp_pkg::STAT_FULL;
                end else begin
                    // remember the inclusive total so recursion is not counted twice
                    slot               = FRAME_IW'(nest_fill);
                    frame_rgn[slot]    = rgn;
                    frame_parent[slot] = active_region;
                    frame_start[slot]  = ev.timestamp;
                    frame_incl[slot]   = incl_total[rgn];
                    nest_fill++;
                    active_region = rgn;
                end
            end
            nrcp_pkg::MODE_END: begin
                if (nest_fill == 0) begin
                    stat = nrcp_pkg::STAT_EMPTY;
                    rgn  = active_region;
                end else begin
                    nest_fill--;
                    slot    = FRAME_IW'(nest_fill);
                    rgn     = frame_rgn[slot];
                    parent  = frame_parent[slot];
                    elapsed = ev.timestamp - frame_start[slot];
                    active_region      = parent;
                    excl_total[parent] = excl_total[parent] - elapsed;
                    excl_total[rgn]    = excl_total[rgn] + elapsed;
                    incl_total[rgn]    = frame_incl[slot] + elapsed;
                    hit_total[rgn]     = hit_total[rgn] + nrcp_pkg::CNT_W'(1);
                end
            end
            default: begin
                // read, spare code too
            end
        endcase
        rep.status           = stat;
        rep.region_out       = rgn;
        rep.inclusive_cycles = incl_total[rgn];
        rep.exclusive_cycles = excl_total[rgn];
        rep.hits             = hit_total[rgn];
        return rep;
    endfunction

    // random event: mostly well-nested start/end pairs over a few hot regions
    function automatic nrcp_pkg::in_item_t next_event();
        nrcp_pkg::in_item_t ev;
        int                 start_pct;
        if ($urandom_range(99) < 3)
            stamp_clock = {$urandom, $urandom};
        else
            stamp_clock = stamp_clock + nrcp_pkg::TS_W'($urandom_range(1, 5000));
        ev.timestamp = stamp_clock;
        if ($urandom_range(99) < 25)
            ev.anchor_index = nrcp_pkg::ANCHOR_W'($urandom_range(255));
        else
            ev.anchor_index = region_pool[3'($urandom_range(5))];
        if ($urandom_range(99) < 12) begin
            ev.mode = $urandom_range(1) ? nrcp_pkg::MODE_READ : MODE_SPARE;
        end else begin
            start_pct = (nest_fill == 0) ? 80 : (nest_fill >= PROF_DEPTH) ? 25 : 52;
            ev.mode = ($urandom_range(99) < start_pct) ? nrcp_pkg::MODE_START
                                                       : nrcp_pkg::MODE_END;
        end
        return ev;
    endfunction

    task automatic flag_mismatch(string what, logic [nrcp_pkg::CNT_W-1:0] want,
                                 logic [nrcp_pkg::CNT_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("mismatch at cycle %0d: %s expected %h got %h", cycle_count, what, want, got);
    endtask

    // presents one item, holding valid and payload until it is taken
    task automatic offer(nrcp_pkg::in_item_t ev);
        if (valid_hold_pct != 0 && $urandom_range(99) < valid_hold_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < valid_hold_pct);
        end
        s_valid <= 1'b1;
        s_item  <= ev;
        do @(posedge aclk); while (!s_ready);
    endtask

    // sends an item and queues the report it should cause
    task automatic issue(nrcp_pkg::in_item_t ev, logic typed, nrcp_pkg::out_item_t want);
        nrcp_pkg::out_item_t predicted;
        offer(ev);
        predicted = account_event(ev);
        pending_reports.push_back(typed ? want : predicted);
    endtask

    // stop sending until every queued report has come back
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_reports.size() != 0);
    endtask

    // result side: random back-pressure and field-by-field check
    always @(posedge aclk) begin
        nrcp_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                flag_mismatch("unexpected item for region", '0,
                              nrcp_pkg::CNT_W'(m_item.region_out));
            end else begin
                want = pending_reports.pop_front();
                if (m_item.status !== want.status)
                    flag_mismatch("status", nrcp_pkg::CNT_W'(want.status),
                                  nrcp_pkg::CNT_W'(m_item.status));
                if (m_item.region_out !== want.region_out)
                    flag_mismatch("region_out", nrcp_pkg::CNT_W'(want.region_out),
                                  nrcp_pkg::CNT_W'(m_item.region_out));
                if (m_item.inclusive_cycles !== want.inclusive_cycles)
                    flag_mismatch("inclusive_cycles", want.inclusive_cycles,
                                  m_item.inclusive_cycles);
                if (m_item.exclusive_cycles !== want.exclusive_cycles)
                    flag_mismatch("exclusive_cycles", want.exclusive_cycles,
                                  m_item.exclusive_cycles);
                if (m_item.hits !== want.hits)
                    flag_mismatch("hits", want.hits, m_item.hits);
            end
        end
        m_ready <= ($urandom_range(99) >= ready_hold_pct);
    end

    // watchdog, generous enough for the table clear and the slowest handshakes
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("nested_region_cycle_profiler_top_tb: errors");
            $finish;
        end
    end

    initial begin
        nrcp_pkg::in_item_t ev;
        int                 row;
        int                 rep;
        int                 phase;
        int                 n;
        int                 valid_hold_by_phase[3];
        int                 ready_hold_by_phase[3];
        valid_hold_by_phase = '{28, 70, 0};
        ready_hold_by_phase = '{70, 28, 0};

        script = '{
            // fresh tables read back as zero, whatever the index or timestamp
            '{'{nrcp_pkg::MODE_READ,  8'h00, 64'h0}, 8'd1, 1'b1,
              zero_report(nrcp_pkg::STAT_OK, 8'h00)},
            '{'{nrcp_pkg::MODE_READ,  8'hFF, 64'hFFFF_FFFF_FFFF_FFFF}, 8'd1, 1'b1,
              zero_report(nrcp_pkg::STAT_OK, 8'hFF)},
            '{'{MODE_SPARE, 8'hA5, 64'h5555_AAAA_5555_AAAA}, 8'd1, 1'b1,
              zero_report(nrcp_pkg::STAT_OK, 8'hA5)},
            // end with nothing open is refused and reports the root
            '{'{nrcp_pkg::MODE_END,   8'h5A, 64'd5}, 8'd1, 1'b1,
              zero_report(nrcp_pkg::STAT_EMPTY, 8'h00)},
            // region 7 entered twice to exercise recursion, then the top index
            '{'{nrcp_pkg::MODE_START, 8'h07, 64'd100}, 8'd1, 1'b1,
              zero_report(nrcp_pkg::STAT_OK, 8'h07)},
            '{'{nrcp_pkg::MODE_START, 8'h07, 64'd150}, 8'd1, 1'b1,
              zero_report(nrcp_pkg::STAT_OK, 8'h07)},
            '{'{nrcp_pkg::MODE_START, 8'hFF, 64'd200}, 8'd1, 1'b1,
              zero_report(nrcp_pkg::STAT_OK, 8'hFF)},
            '{'{nrcp_pkg::MODE_END,   8'h00, 64'd260},  8'd1, 1'b0, '0},
            '{'{nrcp_pkg::MODE_END,   8'h3C, 64'd300},  8'd1, 1'b0, '0},
            '{'{nrcp_pkg::MODE_END,   8'hC3, 64'd1000}, 8'd1, 1'b0, '0},
            // root exclusive total has gone below zero
            '{'{nrcp_pkg::MODE_READ,  8'h00, 64'd1001}, 8'd1, 1'b0, '0},
            // elapsed time across the 64-bit wrap
            '{'{nrcp_pkg::MODE_START, 8'h01, 64'hFFFF_FFFF_FFFF_FFF0}, 8'd1, 1'b0, '0},
            '{'{nrcp_pkg::MODE_END,   8'h01, 64'h10}, 8'd1, 1'b0, '0},
            // root opened as a region, then the stack filled to the brim
            '{'{nrcp_pkg::MODE_START, 8'h00, 64'd2000}, 8'd1,  1'b0, '0},
            '{'{nrcp_pkg::MODE_START, 8'hC3, 64'd2100}, 8'd15, 1'b0, '0},
            '{'{nrcp_pkg::MODE_START, 8'h3C, 64'd3000}, 8'd1,  1'b1,
              zero_report(nrcp_pkg::STAT_FULL, 8'h3C)},
            // unwind every frame, then one end too many
            '{'{nrcp_pkg::MODE_END,   8'h81, 64'h8000_0000_0000_0000}, 8'd16, 1'b0, '0},
            '{'{nrcp_pkg::MODE_END,   8'h7E, 64'h0}, 8'd1, 1'b0, '0},
            '{'{nrcp_pkg::MODE_READ,  8'hC3, 64'h0}, 8'd1, 1'b0, '0}
        };

        // synchronous reset, then the block clears its tables on its own
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (row = 0; row < SCRIPT_ROWS; row++) begin
            for (rep = 0; rep < script[SCRIPT_IW'(row)].reps; rep++) begin
                ev           = script[SCRIPT_IW'(row)].ev;
                ev.timestamp = ev.timestamp + 64'(rep) * 64'd16;
                issue(ev, script[SCRIPT_IW'(row)].typed, script[SCRIPT_IW'(row)].want);
            end
        end

        // random streams under three idling patterns
        for (phase = 0; phase < 3; phase++) begin
            if (phase != 0)
                drain();
            valid_hold_pct = valid_hold_by_phase[2'(phase)];
            ready_hold_pct = ready_hold_by_phase[2'(phase)];
            for (n = 0; n < (RANDOM_ITEMS + 2) / 3; n++)
                issue(next_event(), 1'b0, '0);
        end

        // wait out the last reports plus a little slack for strays
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_reports.size() == 0) begin
            $display("nested_region_cycle_profiler_top_tb: clean");
        end else begin
            $display("nested_region_cycle_profiler_top_tb: errors");
        end
        $finish;
    end

endmodule
